// File: design/lsbbp_pkg.sv
// ----------------------------------------------------------------------------
// lsbbp_pkg
// Types and constants shared by the LSB-first bit packer: command codes,
// store geometry and the request and response transaction layouts.
// ----------------------------------------------------------------------------
package lsbbp_pkg;

   // Byte store geometry (size must be a power of two, addresses wrap)
   localparam int STORE_BYTES    = 4096;
   localparam int ADDR_W         = $clog2(STORE_BYTES);
   localparam int BYTE_W         = 8;
   localparam int MAX_FIELD_BITS = 32;

   // Field widths of the transactions
   localparam int CMD_W   = 2;
   localparam int NBITS_W = 6;
   localparam int VALUE_W = 32;
   localparam int LOC_W   = 15;

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE = 2'd0,
      CMD_POKE  = 2'd1,
      CMD_SEEK  = 2'd2
   } cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [NBITS_W-1:0] num_bits;
      logic [VALUE_W-1:0] value;
      logic [LOC_W-1:0]   bit_loc;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] byte_addr;
      logic [BYTE_W-1:0] byte_value;
      logic              last;
   } rsp_type;

endpackage

// File: design/lsb_first_bit_packer.sv
// ----------------------------------------------------------------------------
// lsb_first_bit_packer
// Packs bit fields LSB first into a byte store with read-modify-write of
// each touched byte; reports every touched byte as address and new value.
// ----------------------------------------------------------------------------
// Sequence: each touched byte is read, then modified and written back and
// reported as a registered response; the write waits while rsp_stall holds
// the output. Five bytes are touched at most. No new request is taken until
// the last byte is written; seek, zero-length and unused commands touch no byte.
// Reset: synchronous; a clearing pass over every byte zeroes the store, and no
// request is taken during it.
module lsb_first_bit_packer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  lsbbp_pkg::req_type   req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lsbbp_pkg::rsp_type   rsp_data
);

   localparam int AW = lsbbp_pkg::ADDR_W;
   localparam int BW = lsbbp_pkg::BYTE_W;
   localparam int NW = lsbbp_pkg::NBITS_W;
   localparam int VW = lsbbp_pkg::VALUE_W;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_READ  = 4'b0100,
      ST_WRITE = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic [AW-1:0]     addr_ff, addr_in;
   logic [2:0]        bit_ff, bit_in;
   logic [NW-1:0]     left_ff, left_in;
   logic [VW-1:0]     val_ff, val_in;
   logic              is_wr_ff, is_wr_in;
   logic [AW-1:0]     run_byte_ff, run_byte_in;
   logic [2:0]        run_bit_ff, run_bit_in;
   logic              rsp_valid_ff, rsp_valid_in;
   lsbbp_pkg::rsp_type rsp_ff, rsp_in;

   logic [BW-1:0]     store [lsbbp_pkg::STORE_BYTES];
   logic [BW-1:0]     rd_data_ff;
   logic              mem_we;
   logic [AW-1:0]     mem_wa;
   logic [BW-1:0]     mem_wd;
   logic              mem_re;

   logic              req_take;
   logic              out_free;
   logic [NW-1:0]     n_sat;
   logic [3:0]        room;
   logic [3:0]        take;
   logic [3:0]        bit_sum;
   logic [BW-1:0]     mask;
   logic [BW-1:0]     new_byte;
   logic              is_last;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Saturate field length
   assign n_sat = (req_data.num_bits > NW'(lsbbp_pkg::MAX_FIELD_BITS))
                  ? NW'(lsbbp_pkg::MAX_FIELD_BITS) : req_data.num_bits;

   // Bits that go into the current byte and its merged value
   assign room     = 4'd8 - {1'b0, bit_ff};
   assign take     = (left_ff > {2'b00, room}) ? room : left_ff[3:0];
   assign bit_sum  = {1'b0, bit_ff} + take;
   assign mask     = (8'hFF >> (4'd8 - take)) << bit_ff;
   assign new_byte = (rd_data_ff & ~mask) | ((val_ff[BW-1:0] << bit_ff) & mask);
   assign is_last  = ({2'b00, take} == left_ff);

   // Store port control
   assign mem_re = (state_ff == ST_READ);
   assign mem_we = (state_ff == ST_CLEAR) || ((state_ff == ST_WRITE) && out_free);
   assign mem_wa = (state_ff == ST_CLEAR) ? clr_ff : addr_ff;
   assign mem_wd = (state_ff == ST_CLEAR) ? '0 : new_byte;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      addr_in      = addr_ff;
      bit_in       = bit_ff;
      left_in      = left_ff;
      val_in       = val_ff;
      is_wr_in     = is_wr_ff;
      run_byte_in  = run_byte_ff;
      run_bit_in   = run_bit_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               left_in  = n_sat;
               val_in   = req_data.value;
               is_wr_in = (req_data.cmd == lsbbp_pkg::CMD_WRITE);
               unique case (req_data.cmd)
                  lsbbp_pkg::CMD_WRITE: begin
                     addr_in = run_byte_ff;
                     bit_in  = run_bit_ff;
                     if (n_sat != '0) begin
                        state_in = ST_READ;
                     end
                  end
                  lsbbp_pkg::CMD_POKE: begin
                     addr_in = AW'(req_data.bit_loc[lsbbp_pkg::LOC_W-1:3]);
                     bit_in  = req_data.bit_loc[2:0];
                     if (n_sat != '0) begin
                        state_in = ST_READ;
                     end
                  end
                  lsbbp_pkg::CMD_SEEK: begin
                     run_byte_in = AW'(req_data.bit_loc[lsbbp_pkg::LOC_W-1:3]);
                     run_bit_in  = req_data.bit_loc[2:0];
                  end
                  default: begin
                     // unused command: ignored
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.byte_addr    = addr_ff;
               rsp_in.byte_value   = new_byte;
               rsp_in.last         = is_last;
               val_in              = val_ff >> take;
               left_in             = left_ff - {2'b00, take};
               bit_in              = bit_sum[2:0];
               if (bit_sum[3]) begin
                  addr_in = addr_ff + 1'b1;
               end
               if (is_last) begin
                  state_in = ST_IDLE;
                  if (is_wr_ff) begin
                     run_byte_in = bit_sum[3] ? addr_ff + 1'b1 : addr_ff;
                     run_bit_in  = bit_sum[2:0];
                  end
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         run_byte_ff  <= '0;
         run_bit_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         run_byte_ff  <= run_byte_in;
         run_bit_ff   <= run_bit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers
   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      bit_ff   <= bit_in;
      left_ff  <= left_in;
      val_ff   <= val_in;
      is_wr_ff <= is_wr_in;
      rsp_ff   <= rsp_in;
   end

   // Byte store: one write and one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= store[addr_ff];
      end
   end

endmodule
